/* src/ipst_pkg.sv */
// shared constants and the quarter-wave entry function for the sine tone generator
package ipst_pkg;

	// default values of the top-level parameters
	localparam int unsigned SAMPLE_RATE_HZ_DEF = 44100;
	localparam int unsigned TABLE_BITS_DEF     = 10;
	localparam int unsigned PHASE_BITS_DEF     = 16;

	// field and register widths
	localparam int unsigned FREQ_W    = 17;
	localparam int unsigned AMP_W     = 16;
	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned IDX_W     = 16;
	localparam int unsigned CFG_W     = 17;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned DVD_W     = FREQ_W + 1;
	localparam int unsigned QENT_W    = 15;
	localparam int unsigned ACC_W     = 30;
	localparam int unsigned MUL_STEPS = AMP_W / 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FREQ = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_AMP  = 1'b1;

	// reset values and limits
	localparam logic [FREQ_W-1:0] FREQ_RESET = 17'd440;
	localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd32768;
	localparam logic [AMP_W-1:0]  FULL_AMP   = 16'd32768;

	// pi/2 in Q30
	localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

	// taylor series denominators (2n)(2n+1) for n = 1..10
	localparam int unsigned TAYLOR_DEN [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

	// one quarter-wave entry in Q0.15, evaluated at elaboration
	function automatic logic [QENT_W-1:0] quarter_entry(input int unsigned k,
		input int unsigned tbits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        val;
		logic signed [63:0] sum;
		x = (64'(k) * HALFPI_Q30) >> tbits;
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(x);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / 64'(TAYLOR_DEN[n-1]);
			if (n[0]) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		val = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (val > 64'd32767) begin
			val = 64'd32767;
		end
		return val[QENT_W-1:0];
	endfunction

endpackage

/* src/integer_period_sine_tone.sv */
// sine tone generator with a whole-sample period, bit-serial divider and radix-4 multiplier
//
// Usage: each item taken on the tick channel (tick_valid high, tick_stall low) yields one
// stereo frame on the frame channel (frame_valid high, frame_stall low). restart clears the
// sample index before the frame is made. freq_hz (index 0) and amplitude_q15 (index 1) are
// written through cfg_we / cfg_index / cfg_data while the block is idle.
// A new tick is taken only once the previous frame has moved into the output register. The
// phase divider resolves one quotient bit a cycle; the amplitude multiply works two bits a
// cycle. After reset or a freq_hz write, the first item first recomputes the period in the
// same divider, unless freq_hz is zero. An invalid period (zero) skips the phase division
// and the multiply and gives a silent frame.
// Reset: freq_hz 440, amplitude full scale, sample index 0, no frame pending.
// A stalled frame holds in the output register; the block still accepts the next tick and
// works on it, then waits with the finished frame until the output register frees up.
module integer_period_sine_tone #(
	parameter int unsigned SAMPLE_RATE_HZ = ipst_pkg::SAMPLE_RATE_HZ_DEF,
	parameter int unsigned TABLE_BITS     = ipst_pkg::TABLE_BITS_DEF,
	parameter int unsigned PHASE_BITS     = ipst_pkg::PHASE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [ipst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ipst_pkg::CFG_W-1:0]           cfg_data,
	// tick channel
	input  logic                                 tick_valid,
	output logic                                 tick_stall,
	input  logic                                 restart,
	// frame channel
	output logic                                 frame_valid,
	input  logic                                 frame_stall,
	output logic signed [ipst_pkg::SAMPLE_W-1:0] left_sample,
	output logic signed [ipst_pkg::SAMPLE_W-1:0] right_sample,
	output logic                                 period_end,
	output logic                                 invalid_period
);

	localparam int unsigned DVD_W  = ipst_pkg::DVD_W;
	localparam int unsigned IDX_W  = ipst_pkg::IDX_W;
	localparam int unsigned QENT_W = ipst_pkg::QENT_W;
	localparam int unsigned ACC_W  = ipst_pkg::ACC_W;
	localparam int unsigned AMP_W  = ipst_pkg::AMP_W;
	localparam int unsigned QUO_W  = (PHASE_BITS > DVD_W) ? PHASE_BITS : DVD_W;
	localparam int unsigned CNT_W  = $clog2(QUO_W + 1);
	localparam int unsigned FULL_W = TABLE_BITS + 2;
	localparam int unsigned QDEPTH = (1 << TABLE_BITS) + 1;
	localparam int          SH     = int'(PHASE_BITS) - int'(TABLE_BITS) - 2;
	localparam logic [TABLE_BITS:0] QN = (TABLE_BITS + 1)'(1 << TABLE_BITS);
	localparam logic [DVD_W-1:0]    TWO_SR = DVD_W'(2 * SAMPLE_RATE_HZ);

	// quarter-wave table, built at elaboration
	typedef logic [QENT_W-1:0] qtab_t [QDEPTH];

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int k = 0; k < QDEPTH; k++) begin
			t[k] = ipst_pkg::quarter_entry(k, TABLE_BITS);
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PDIV  = 6'b000010,
		S_PREP  = 6'b000100,
		S_PHASE = 6'b001000,
		S_ROM   = 6'b010000,
		S_MUL   = 6'b100000
	} state_t;

	// S_OUT is folded into its own code below to keep the encoding one-hot
	typedef enum logic [1:0] {
		O_NONE = 2'b01,
		O_WAIT = 2'b10
	} ostate_t;

	state_t                  state_q;
	ostate_t                 ostate_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    period_ok_q;
	logic [IDX_W-1:0]        period_q;
	logic [IDX_W-1:0]        sample_index_q;
	logic [ipst_pkg::FREQ_W-1:0] freq_q;
	logic [AMP_W-1:0]        amp_q;
	logic                    restart_q;

	logic [DVD_W-1:0]        rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic [DVD_W-1:0]        div_q;
	logic [QENT_W-1:0]       rom_q;
	logic [AMP_W-1:0]        mul_q;
	logic [ACC_W-1:0]        acc_q;
	logic                    neg_q;
	logic                    pend_q;
	logic                    inv_q;

	logic                    frame_valid_q;
	logic [ipst_pkg::SAMPLE_W-1:0] sample_q;
	logic                    period_end_q;
	logic                    invalid_q;

	// division step: one quotient bit a cycle
	logic [DVD_W:0]          rem_sh;
	logic                    sub_ge;
	logic [DVD_W-1:0]        rem_nxt;
	logic [QUO_W-1:0]        quo_nxt;

	assign rem_sh  = {rem_q, quo_q[QUO_W-1]};
	assign sub_ge  = rem_sh >= {1'b0, div_q};
	assign rem_nxt = sub_ge ? DVD_W'(rem_sh - {1'b0, div_q}) : rem_sh[DVD_W-1:0];
	assign quo_nxt = {quo_q[QUO_W-2:0], sub_ge};

	// index handling for the item being prepared
	logic [IDX_W-1:0]        idx_raw;
	logic [IDX_W-1:0]        idx_cur;
	logic [IDX_W:0]          idx_inc;
	logic [IDX_W-1:0]        idx_next;
	logic                    idx_last;

	assign idx_raw  = restart_q ? '0 : sample_index_q;
	assign idx_cur  = (idx_raw >= period_q) ? '0 : idx_raw;
	assign idx_inc  = {1'b0, idx_cur} + (IDX_W + 1)'(1);
	assign idx_next = (idx_inc >= {1'b0, period_q}) ? '0 : idx_inc[IDX_W-1:0];
	assign idx_last = idx_cur == (period_q - IDX_W'(1));

	// phase to table position
	logic [PHASE_BITS-1:0]   phase;
	logic [FULL_W-1:0]       full;
	logic [TABLE_BITS-1:0]   pos;
	logic [TABLE_BITS:0]     rom_addr;

	assign phase = quo_q[PHASE_BITS-1:0];

	generate
		if (SH >= 0) begin : g_phase_shr
			assign full = phase[PHASE_BITS-1 -: FULL_W];
		end else begin : g_phase_shl
			localparam int unsigned LSH = -SH;
			assign full = {phase, {LSH{1'b0}}};
		end
	endgenerate

	assign pos      = full[TABLE_BITS-1:0];
	assign rom_addr = full[TABLE_BITS] ? (QN - {1'b0, pos}) : {1'b0, pos};

	// amplitude saturation and radix-4 partial product
	logic [AMP_W-1:0]        amp_sat;
	logic [1:0]              digit;
	logic [QENT_W+1:0]       pp;
	logic [ACC_W-1:0]        acc_nxt;

	assign amp_sat = (amp_q > ipst_pkg::FULL_AMP) ? ipst_pkg::FULL_AMP : amp_q;
	assign digit   = mul_q[AMP_W-1 -: 2];
	assign pp      = (digit[0] ? (QENT_W + 2)'(rom_q) : '0)
		+ (digit[1] ? (QENT_W + 2)'({rom_q, 1'b0}) : '0);
	assign acc_nxt = {acc_q[ACC_W-3:0], 2'b00} + ACC_W'(pp);

	// final sample from the product magnitude
	logic [QENT_W-1:0]       mag;
	logic [ipst_pkg::SAMPLE_W-1:0] sample_res;
	logic                    out_free;

	assign mag        = acc_q[ACC_W-1 -: QENT_W];
	assign sample_res = neg_q ? (ipst_pkg::SAMPLE_W'(0) - {1'b0, mag}) : {1'b0, mag};
	assign out_free   = !frame_valid_q || !frame_stall;

	// control: sequencer, counters, index, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ostate_q       <= O_NONE;
			cnt_q          <= '0;
			period_ok_q    <= 1'b0;
			sample_index_q <= '0;
			freq_q         <= ipst_pkg::FREQ_RESET;
			amp_q          <= ipst_pkg::AMP_RESET;
			frame_valid_q  <= 1'b0;
		end else begin
			// output valid: set when a finished frame moves out, cleared once taken
			if ((ostate_q == O_WAIT) && out_free) begin
				frame_valid_q <= 1'b1;
			end else if (!frame_stall) begin
				frame_valid_q <= 1'b0;
			end
			unique case (ostate_q)
				O_NONE: begin
					unique case (state_q)
						S_IDLE: begin
							if (tick_valid) begin
								if (period_ok_q) begin
									state_q <= S_PREP;
								end else if (freq_q == '0) begin
									period_ok_q <= 1'b1;
									state_q     <= S_PREP;
								end else begin
									cnt_q   <= CNT_W'(QUO_W);
									state_q <= S_PDIV;
								end
							end
						end
						S_PDIV: begin
							cnt_q <= cnt_q - CNT_W'(1);
							if (cnt_q == CNT_W'(1)) begin
								period_ok_q <= 1'b1;
								state_q     <= S_PREP;
							end
						end
						S_PREP: begin
							if (period_q == '0) begin
								sample_index_q <= '0;
								ostate_q       <= O_WAIT;
							end else begin
								sample_index_q <= idx_next;
								cnt_q          <= CNT_W'(PHASE_BITS);
								state_q        <= S_PHASE;
							end
						end
						S_PHASE: begin
							cnt_q <= cnt_q - CNT_W'(1);
							if (cnt_q == CNT_W'(1)) begin
								state_q <= S_ROM;
							end
						end
						S_ROM: begin
							cnt_q   <= CNT_W'(ipst_pkg::MUL_STEPS);
							state_q <= S_MUL;
						end
						S_MUL: begin
							cnt_q <= cnt_q - CNT_W'(1);
							if (cnt_q == CNT_W'(1)) begin
								ostate_q <= O_WAIT;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				O_WAIT: begin
					if (out_free) begin
						ostate_q <= O_NONE;
						state_q  <= S_IDLE;
					end
				end
				default: ostate_q <= O_NONE;
			endcase
			// register writes must arrive only while idle; the block itself does not enforce it
			if (cfg_we) begin
				unique case (cfg_index)
					ipst_pkg::REG_FREQ: begin
						freq_q      <= cfg_data[ipst_pkg::FREQ_W-1:0];
						period_ok_q <= 1'b0;
					end
					ipst_pkg::REG_AMP: amp_q <= cfg_data[AMP_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// datapath: divider, table read, multiplier and output payload
	always_ff @(posedge clk) begin
		if (ostate_q == O_WAIT) begin
			if (out_free) begin
				sample_q     <= sample_res;
				period_end_q <= pend_q;
				invalid_q    <= inv_q;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					restart_q <= restart;
					if (!period_ok_q) begin
						period_q <= '0;
						rem_q    <= '0;
						quo_q    <= QUO_W'(TWO_SR + {1'b0, freq_q});
						div_q    <= {freq_q, 1'b0};
					end
				end
				S_PDIV: begin
					rem_q <= rem_nxt;
					quo_q <= quo_nxt;
					if (cnt_q == CNT_W'(1)) begin
						period_q <= quo_nxt[IDX_W-1:0];
					end
				end
				S_PREP: begin
					pend_q <= (period_q != '0) && idx_last;
					inv_q  <= period_q == '0;
					neg_q  <= 1'b0;
					acc_q  <= '0;
					rem_q  <= DVD_W'(idx_cur);
					quo_q  <= '0;
					div_q  <= DVD_W'(period_q);
				end
				S_PHASE: begin
					rem_q <= rem_nxt;
					quo_q <= quo_nxt;
				end
				S_ROM: begin
					rom_q <= QTAB[rom_addr];
					neg_q <= full[TABLE_BITS+1];
					mul_q <= amp_sat;
					acc_q <= '0;
				end
				S_MUL: begin
					acc_q <= acc_nxt;
					mul_q <= {mul_q[AMP_W-3:0], 2'b00};
				end
				default: ;
			endcase
		end
	end

	assign tick_stall     = !((state_q == S_IDLE) && (ostate_q == O_NONE));
	assign frame_valid    = frame_valid_q;
	assign left_sample    = sample_q;
	assign right_sample   = sample_q;
	assign period_end     = period_end_q;
	assign invalid_period = invalid_q;

	// invalid frames are silent and never close a period
	assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && invalid_period) |-> (left_sample == '0 && !period_end))
		else $error("invalid frame carries a nonzero sample or period end");

	// divider remainder stays below the divisor while a division runs
	assert property (@(posedge clk) disable iff (!arst_n)
		(ostate_q == O_NONE && (state_q == S_PDIV || state_q == S_PHASE)) |-> (rem_q < div_q))
		else $error("divider remainder reached the divisor");

	// the stored index always lies inside the period after a frame is prepared
	assert property (@(posedge clk) disable iff (!arst_n)
		(ostate_q == O_NONE && state_q == S_PREP && period_q != '0)
		|=> (sample_index_q < period_q))
		else $error("sample index left the period");

	// the period is only recomputed while it is marked stale
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PDIV) |-> !period_ok_q)
		else $error("period division runs on an up-to-date period");

endmodule

/* test/tb_integer_period_sine_tone.sv */
// self-checking testbench for the integer-period sine tone generator
`timescale 1ns / 100ps

module tb_integer_period_sine_tone;

	localparam int unsigned TONE_FS_HZ   = ipst_pkg::SAMPLE_RATE_HZ_DEF;
	localparam int unsigned TBL_BITS     = ipst_pkg::TABLE_BITS_DEF;
	localparam int unsigned PH_BITS      = ipst_pkg::PHASE_BITS_DEF;
	localparam int unsigned SAMPLE_W     = ipst_pkg::SAMPLE_W;
	localparam int unsigned FREQ_W       = ipst_pkg::FREQ_W;
	localparam int unsigned AMP_W        = ipst_pkg::AMP_W;
	localparam int unsigned CFG_IDX_W    = ipst_pkg::CFG_IDX_W;
	localparam int unsigned CFG_W        = ipst_pkg::CFG_W;
	localparam int unsigned QUARTER_LEN  = 1 << TBL_BITS;
	localparam int unsigned ANGLE_SHIFT  = PH_BITS - TBL_BITS - 2;
	localparam int          SETTLE_CYCLES = 48;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          DIR_ROWS     = 22;
	localparam int          RAND_PHASES  = 16;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_smp;
		logic signed [SAMPLE_W-1:0] right_smp;
		logic                       at_period_end;
		logic                       no_period;
	} frame_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [AMP_W-1:0]  amp;
		logic              rs;
		logic              typed;
		frame_t            want;
	} tick_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       tick_valid;
	logic                       tick_stall;
	logic                       restart;
	logic                       frame_valid;
	logic                       frame_stall;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                       period_end;
	logic                       invalid_period;

	// tone model state
	int unsigned       sine_quarter [0:QUARTER_LEN];
	logic [FREQ_W-1:0] tone_freq;
	logic [AMP_W-1:0]  tone_amp;
	int unsigned       tone_index;
	frame_t            expected_frames [$];
	int                mismatch_count;

	// idling and hold-off control
	int                send_idle_pct;
	int                recv_idle_pct;
	int                hold_requests;
	int                holds_served;
	int                hold_left;

	tick_row_t         steer_rows [DIR_ROWS];

	integer_period_sine_tone uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.tick_valid     (tick_valid),
		.tick_stall     (tick_stall),
		.restart        (restart),
		.frame_valid    (frame_valid),
		.frame_stall    (frame_stall),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.period_end     (period_end),
		.invalid_period (invalid_period)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#20000000;
		$display("integer_period_sine_tone verification failed");
		$finish;
	end

	// quarter-wave entry in Q0.15 from an eleven-term taylor series in Q30
	function automatic int unsigned quarter_sine(input int unsigned k);
		logic [63:0]        ang;
		logic [63:0]        ang_sq;
		logic [63:0]        t;
		logic [63:0]        r;
		logic signed [63:0] acc;
		ang = (64'(k) * ipst_pkg::HALFPI_Q30) >> TBL_BITS;
		ang_sq = (ang * ang) >> 30;
		t = ang;
		acc = signed'(ang);
		for (int n = 1; n <= 10; n++) begin
			t = ((t * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - signed'(t);
			end else begin
				acc = acc + signed'(t);
			end
		end
		if (acc < 0) begin
			acc = '0;
		end
		r = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[31:0];
	endfunction

	// next frame of the tone, advancing the sample index
	function automatic frame_t next_tone_frame(input logic rs);
		frame_t            f;
		int unsigned       f_hz;
		int unsigned       period;
		int unsigned       idx;
		int unsigned       mag;
		int unsigned       amp;
		logic [63:0]       ph;
		logic [TBL_BITS+1:0] full;
		logic [1:0]        quad;
		int unsigned       pos;
		f = '0;
		if (rs) begin
			tone_index = 0;
		end
		f_hz = 32'(tone_freq);
		period = (f_hz == 0) ? 0 : (2 * TONE_FS_HZ + f_hz) / (2 * f_hz);
		if (period == 0) begin
			tone_index = 0;
			f.no_period = 1'b1;
			return f;
		end
		idx = (tone_index >= period) ? 0 : tone_index;
		ph = (64'(idx) << PH_BITS) / 64'(period);
		full = (TBL_BITS + 2)'(ph >> ANGLE_SHIFT);
		quad = full[TBL_BITS+1:TBL_BITS];
		pos = 32'(full[TBL_BITS-1:0]);
		mag = quad[0] ? sine_quarter[QUARTER_LEN - pos] : sine_quarter[pos];
		amp = (tone_amp > ipst_pkg::FULL_AMP) ? 32'(ipst_pkg::FULL_AMP) : 32'(tone_amp);
		mag = (mag * amp) >> 15;
		f.left_smp = quad[1] ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
		f.right_smp = f.left_smp;
		f.at_period_end = (idx == period - 1);
		tone_index = (idx + 1 >= period) ? 0 : idx + 1;
		return f;
	endfunction

	// random tone frequency, including zero, very low and out-of-range values
	function automatic logic [FREQ_W-1:0] pick_freq();
		case ($urandom_range(0, 9))
			0: begin
				return FREQ_W'($urandom_range(1, 20));
			end
			1: begin
				return FREQ_W'($urandom_range(88201, 131071));
			end
			2: begin
				return ($urandom_range(0, 1) == 0) ? '0 : FREQ_W'($urandom);
			end
			3: begin
				return FREQ_W'($urandom_range(11025, 88200));
			end
			4, 5: begin
				return FREQ_W'($urandom_range(20, 400));
			end
			default: begin
				return FREQ_W'($urandom_range(400, 11025));
			end
		endcase
	endfunction

	// random volume, including zero and values above full scale
	function automatic logic [AMP_W-1:0] pick_amp();
		case ($urandom_range(0, 5))
			0: begin
				return '0;
			end
			1: begin
				return AMP_W'($urandom_range(32769, 65535));
			end
			2: begin
				return ipst_pkg::FULL_AMP;
			end
			default: begin
				return AMP_W'($urandom_range(0, 32767));
			end
		endcase
	endfunction

	// offer one tick item and record its expected frame once taken
	task automatic send_tick(input logic rs, input logic typed, input frame_t want);
		frame_t f;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		restart <= rs;
		@(posedge clk);
		while (tick_stall) begin
			@(posedge clk);
		end
		f = next_tone_frame(rs);
		expected_frames.push_back(typed ? want : f);
	endtask

	// stop offering and let every pending frame come out
	task automatic settle();
		tick_valid <= 1'b0;
		while (expected_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back
	task automatic apply_settings(input logic [FREQ_W-1:0] f, input logic [AMP_W-1:0] a);
		cfg_we <= 1'b1;
		cfg_index <= ipst_pkg::REG_FREQ;
		cfg_data <= CFG_W'(f);
		@(posedge clk);
		cfg_index <= ipst_pkg::REG_AMP;
		cfg_data <= CFG_W'(a);
		@(posedge clk);
		cfg_we <= 1'b0;
		tone_freq = f;
		tone_amp = a;
	endtask

	// compare one taken frame with the oldest expectation
	task automatic check_frame();
		frame_t want;
		if (expected_frames.size() == 0) begin
			$display("%0t: unexpected frame, expected none, got left %0d right %0d end %0b inv %0b",
				$time, left_sample, right_sample, period_end, invalid_period);
			mismatch_count++;
		end else begin
			want = expected_frames.pop_front();
			if (want.left_smp !== left_sample) begin
				$display("%0t: left_sample expected %0d got %0d", $time, want.left_smp,
					left_sample);
				mismatch_count++;
			end
			if (want.right_smp !== right_sample) begin
				$display("%0t: right_sample expected %0d got %0d", $time, want.right_smp,
					right_sample);
				mismatch_count++;
			end
			if (want.at_period_end !== period_end) begin
				$display("%0t: period_end expected %0b got %0b", $time, want.at_period_end,
					period_end);
				mismatch_count++;
			end
			if (want.no_period !== invalid_period) begin
				$display("%0t: invalid_period expected %0b got %0b", $time, want.no_period,
					invalid_period);
				mismatch_count++;
			end
		end
	endtask

	// frame side: check taken items and drive the stall
	initial begin
		holds_served = 0;
		hold_left = 0;
		frame_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && frame_valid && !frame_stall) begin
				check_frame();
			end
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				frame_stall <= 1'b1;
			end else begin
				frame_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// directed items: extremes, saturation, beyond-period index and invalid periods
	initial begin
		steer_rows = '{
			'{17'd440,    16'd32768, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
			'{17'd440,    16'd32768, 1'b0, 1'b0, '0},
			'{17'd440,    16'd32768, 1'b1, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
			'{17'd440,    16'd32768, 1'b0, 1'b0, '0},
			'{17'd11025,  16'd32768, 1'b0, 1'b0, '0},
			'{17'd11025,  16'd32768, 1'b0, 1'b0, '0},
			'{17'd11025,  16'd32768, 1'b0, 1'b0, '0},
			'{17'd11025,  16'd32768, 1'b0, 1'b0, '0},
			'{17'd11025,  16'd65535, 1'b1, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
			'{17'd11025,  16'd65535, 1'b0, 1'b0, '0},
			'{17'd11025,  16'd32767, 1'b0, 1'b0, '0},
			'{17'd11025,  16'd32767, 1'b0, 1'b0, '0},
			'{17'd11025,  16'd0,     1'b0, 1'b0, '0},
			'{17'd44100,  16'd32768, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
			'{17'd88200,  16'd32768, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
			'{17'd88201,  16'd32768, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b1}},
			'{17'd0,      16'd32768, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b1}},
			'{17'd131071, 16'd32768, 1'b1, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b1}},
			'{17'd1,      16'd32768, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
			'{17'd1,      16'd32768, 1'b0, 1'b0, '0},
			'{17'd20000,  16'd65535, 1'b0, 1'b0, '0},
			'{17'd20000,  16'd65535, 1'b1, 1'b0, '0}
		};
	end

	// stimulus and end of run
	initial begin
		int n_items;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= ipst_pkg::REG_FREQ;
		cfg_data <= '0;
		tick_valid <= 1'b0;
		restart <= 1'b0;
		mismatch_count = 0;
		hold_requests = 0;
		send_idle_pct = 30;
		recv_idle_pct = 55;
		tone_freq = ipst_pkg::FREQ_RESET;
		tone_amp = ipst_pkg::AMP_RESET;
		tone_index = 0;
		for (int k = 0; k <= QUARTER_LEN; k++) begin
			sine_quarter[k] = quarter_sine(k);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (steer_rows[r].freq != tone_freq || steer_rows[r].amp != tone_amp) begin
				settle();
				apply_settings(steer_rows[r].freq, steer_rows[r].amp);
			end
			send_tick(steer_rows[r].rs, steer_rows[r].typed, steer_rows[r].want);
		end

		// random phases, each with its own settings
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p < 6) begin
				send_idle_pct = 30;
				recv_idle_pct = 55;
			end else if (p < 11) begin
				send_idle_pct = 55;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			settle();
			apply_settings(pick_freq(), pick_amp());
			// long receiver hold-off while ticks keep coming
			if (p == 11) begin
				hold_requests <= hold_requests + 1;
			end
			n_items = $urandom_range(70, 130);
			repeat (n_items) begin
				send_tick($urandom_range(0, 24) == 0, 1'b0, '0);
			end
		end

		settle();
		if (mismatch_count == 0 && expected_frames.size() == 0) begin
			$display("integer_period_sine_tone verification clean");
		end else begin
			$display("integer_period_sine_tone verification failed");
		end
		$finish;
	end

endmodule

/* integer_period_sine_tone.f */
src/ipst_pkg.sv
src/integer_period_sine_tone.sv
test/tb_integer_period_sine_tone.sv
